// ===== sv/rcp_pkg.sv =====
// Package for the command parser: payload types, state encoding and byte codes.
package rcp_pkg;

  localparam int ARG_INDEX_BITS = 16;
  localparam int LENGTH_BITS    = 30;
  localparam int MAX_ARGS_BITS  = 16;
  localparam int CFG_IDX_BITS   = 2;

  localparam logic [7:0] CH_STAR   = 8'h2A;
  localparam logic [7:0] CH_DOLLAR = 8'h24;
  localparam logic [7:0] CH_CR     = 8'h0D;
  localparam logic [7:0] CH_LF     = 8'h0A;
  localparam logic [7:0] CH_ZERO   = 8'h30;
  localparam logic [7:0] CH_NINE   = 8'h39;

  localparam logic [CFG_IDX_BITS-1:0] CFG_MAX_ARGS     = 2'd0;
  localparam logic [CFG_IDX_BITS-1:0] CFG_MAX_BULK_LEN = 2'd1;

  localparam logic [MAX_ARGS_BITS-1:0] MAX_ARGS_RST     = 16'd1024;
  localparam logic [LENGTH_BITS-1:0]   MAX_BULK_LEN_RST = 30'd536870912;

  typedef enum logic [3:0] {
    PH_STAR,
    PH_CNT,
    PH_CNT_LF,
    PH_DOLLAR,
    PH_LEN,
    PH_LEN_LF,
    PH_DATA,
    PH_SKIP1,
    PH_SKIP2,
    PH_ERR
  } phase_t;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       restart;
  } in_item_t;

  typedef struct packed {
    logic                      payload_valid;
    logic [7:0]                payload_byte;
    logic [ARG_INDEX_BITS-1:0] arg_index;
    logic                      arg_end;
    logic [LENGTH_BITS-1:0]    arg_length;
    logic                      command_end;
    logic [ARG_INDEX_BITS-1:0] arg_count;
    logic                      format_error;
  } out_item_t;

endpackage

// ===== sv/resp_command_parser_top.sv =====
// Top level of the command parser: byte-stream header decoder and argument framer.
// The parser takes one byte of the request stream per clock cycle; the header digit
// check, the times-ten accumulate and the limit compare all sit
// between the state registers and the output register, so the result of a byte appears
// on the out_ channel in the cycle after the byte is accepted. Bytes that finish nothing
// (markers, digits, CR, skipped trailer bytes) produce no out_ beat. The input stalls
// only while a result is held in the output register and the out_ side is stalling;
// otherwise a new byte is taken every cycle. After a format error every byte is dropped
// without a result until a byte arrives with restart set. Limits are written through
// the cfg_ port, which is always ready, and should only change while the parser is idle.
module resp_command_parser_top
  import rcp_pkg::*;
(
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    in_valid,
  output logic                    in_stall,
  input  in_item_t                in_data,
  output logic                    out_valid,
  input  logic                    out_stall,
  output out_item_t               out_data,
  input  logic                    cfg_valid,
  output logic                    cfg_ready,
  input  logic [CFG_IDX_BITS-1:0] cfg_index,
  input  logic [LENGTH_BITS-1:0]  cfg_data
);

  localparam int ACC_BITS = LENGTH_BITS + 4;

  logic [MAX_ARGS_BITS-1:0]  max_args_r;
  logic [LENGTH_BITS-1:0]    max_bulk_r;

  phase_t                    phase_r, phase_nxt, ph;
  logic [LENGTH_BITS-1:0]    num_r, num_nxt, num;
  logic                      seen_r, seen_nxt, seen;
  logic [ARG_INDEX_BITS-1:0] total_r, total_nxt, total;
  logic [ARG_INDEX_BITS-1:0] done_r, done_nxt, done_cnt;
  logic [LENGTH_BITS-1:0]    left_r, left_nxt, left;
  logic [LENGTH_BITS-1:0]    curlen_r, curlen_nxt, curlen;

  logic                      out_valid_r;
  out_item_t                 out_data_r;
  out_item_t                 res;
  logic                      res_valid;

  logic                      in_acc;
  logic [7:0]                b;
  logic                      is_cr, is_digit, over, hdr_err;
  logic [ACC_BITS-1:0]       acc_sum, limit_ext;
  logic [LENGTH_BITS-1:0]    left_dec;
  logic [ARG_INDEX_BITS-1:0] done_inc;

  assign in_acc    = in_valid & ~in_stall;
  assign in_stall  = out_valid_r & out_stall;
  assign cfg_ready = 1'b1;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // Restart acts before the byte, so the byte is decoded against the start state.
  always_comb begin
    if (in_data.restart) begin
      ph       = PH_STAR;
      num      = '0;
      seen     = 1'b0;
      total    = '0;
      done_cnt = '0;
      left     = '0;
      curlen   = '0;
    end else begin
      ph       = phase_r;
      num      = num_r;
      seen     = seen_r;
      total    = total_r;
      done_cnt = done_r;
      left     = left_r;
      curlen   = curlen_r;
    end
  end

  assign b        = in_data.data_byte;
  assign is_cr    = (b == CH_CR);
  assign is_digit = (b >= CH_ZERO) && (b <= CH_NINE);
  assign acc_sum  = {1'b0, num, 3'b000} + {3'b000, num, 1'b0}
                  + {{(ACC_BITS-4){1'b0}}, b[3:0]};
  assign limit_ext = (ph == PH_CNT) ? {{(ACC_BITS-MAX_ARGS_BITS){1'b0}}, max_args_r}
                                    : {4'b0000, max_bulk_r};
  assign over     = acc_sum > limit_ext;
  assign hdr_err  = is_cr ? ~seen : (~is_digit | over);
  assign left_dec = left - 1'b1;
  assign done_inc = done_cnt + 1'b1;

  // Next state.
  always_comb begin
    phase_nxt  = ph;
    num_nxt    = num;
    seen_nxt   = seen;
    total_nxt  = total;
    done_nxt   = done_cnt;
    left_nxt   = left;
    curlen_nxt = curlen;
    unique case (ph)
      PH_STAR: begin
        if (b != CH_STAR) begin
          phase_nxt = PH_ERR;
        end else begin
          num_nxt   = '0;
          seen_nxt  = 1'b0;
          phase_nxt = PH_CNT;
        end
      end
      PH_CNT, PH_LEN: begin
        if (hdr_err) begin
          phase_nxt = PH_ERR;
        end else if (is_cr) begin
          phase_nxt = (ph == PH_CNT) ? PH_CNT_LF : PH_LEN_LF;
        end else begin
          num_nxt  = acc_sum[LENGTH_BITS-1:0];
          seen_nxt = 1'b1;
        end
      end
      PH_CNT_LF: begin
        if (b != CH_LF) begin
          phase_nxt = PH_ERR;
        end else begin
          total_nxt = num[ARG_INDEX_BITS-1:0];
          done_nxt  = '0;
          num_nxt   = '0;
          seen_nxt  = 1'b0;
          phase_nxt = (num[ARG_INDEX_BITS-1:0] == '0) ? PH_STAR : PH_DOLLAR;
        end
      end
      PH_DOLLAR: begin
        if (b != CH_DOLLAR) begin
          phase_nxt = PH_ERR;
        end else begin
          num_nxt   = '0;
          seen_nxt  = 1'b0;
          phase_nxt = PH_LEN;
        end
      end
      PH_LEN_LF: begin
        if (b != CH_LF) begin
          phase_nxt = PH_ERR;
        end else begin
          curlen_nxt = num;
          left_nxt   = num;
          num_nxt    = '0;
          seen_nxt   = 1'b0;
          phase_nxt  = (num == '0) ? PH_SKIP1 : PH_DATA;
        end
      end
      PH_DATA: begin
        left_nxt = left_dec;
        if (left_dec == '0) begin
          phase_nxt = PH_SKIP1;
        end
      end
      PH_SKIP1: begin
        phase_nxt = PH_SKIP2;
      end
      PH_SKIP2: begin
        done_nxt  = done_inc;
        phase_nxt = (done_inc >= total) ? PH_STAR : PH_DOLLAR;
      end
      PH_ERR: begin
        phase_nxt = PH_ERR;
      end
      default: begin
        phase_nxt = PH_ERR;
      end
    endcase
  end

  // Result of the byte, if any.
  always_comb begin
    res       = '0;
    res_valid = 1'b0;
    unique case (ph)
      PH_STAR, PH_DOLLAR: begin
        if (b != ((ph == PH_STAR) ? CH_STAR : CH_DOLLAR)) begin
          res.format_error = 1'b1;
          res_valid        = 1'b1;
        end
      end
      PH_CNT, PH_LEN: begin
        if (hdr_err) begin
          res.format_error = 1'b1;
          res_valid        = 1'b1;
        end
      end
      PH_CNT_LF: begin
        if (b != CH_LF) begin
          res.format_error = 1'b1;
          res_valid        = 1'b1;
        end else if (num[ARG_INDEX_BITS-1:0] == '0) begin
          res.command_end = 1'b1;
          res_valid       = 1'b1;
        end
      end
      PH_LEN_LF: begin
        if (b != CH_LF) begin
          res.format_error = 1'b1;
          res_valid        = 1'b1;
        end else if (num == '0) begin
          res.arg_index = done_cnt;
          res.arg_end   = 1'b1;
          res_valid     = 1'b1;
        end
      end
      PH_DATA: begin
        res.payload_valid = 1'b1;
        res.payload_byte  = b;
        res.arg_index     = done_cnt;
        if (left_dec == '0) begin
          res.arg_end    = 1'b1;
          res.arg_length = curlen;
        end
        res_valid = 1'b1;
      end
      PH_SKIP2: begin
        if (done_inc >= total) begin
          res.command_end = 1'b1;
          res.arg_count   = total;
          res_valid       = 1'b1;
        end
      end
      PH_SKIP1, PH_ERR: begin
        res_valid = 1'b0;
      end
      default: begin
        res_valid = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      max_args_r  <= MAX_ARGS_RST;
      max_bulk_r  <= MAX_BULK_LEN_RST;
      phase_r     <= PH_STAR;
      num_r       <= '0;
      seen_r      <= 1'b0;
      total_r     <= '0;
      done_r      <= '0;
      left_r      <= '0;
      curlen_r    <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        if (cfg_index == CFG_MAX_ARGS) begin
          max_args_r <= cfg_data[MAX_ARGS_BITS-1:0];
        end else if (cfg_index == CFG_MAX_BULK_LEN) begin
          max_bulk_r <= cfg_data;
        end
      end
      if (in_acc) begin
        phase_r  <= phase_nxt;
        num_r    <= num_nxt;
        seen_r   <= seen_nxt;
        total_r  <= total_nxt;
        done_r   <= done_nxt;
        left_r   <= left_nxt;
        curlen_r <= curlen_nxt;
      end
      if (in_acc && res_valid) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc && res_valid) begin
      out_data_r <= res;
    end
  end

endmodule

// ===== dv/resp_command_parser_top_test.sv =====
`timescale 1ns / 1ps
// Self-checking testbench for resp_command_parser_top with its own byte-level parse predictor.
module resp_command_parser_top_test;
  import rcp_pkg::*;

  logic                    clk       = 1'b0;
  logic                    rst_n     = 1'b0;
  logic                    in_valid  = 1'b0;
  logic                    in_stall;
  in_item_t                in_data   = '0;
  logic                    out_valid;
  out_item_t               out_data;
  logic                    cfg_valid = 1'b0;
  logic                    cfg_ready;
  logic [CFG_IDX_BITS-1:0] cfg_index = '0;
  logic [LENGTH_BITS-1:0]  cfg_data  = '0;

  // Random receiver stalls and the long hold-off are kept apart and merged here.
  logic rand_stall = 1'b0;
  logic hold_stall = 1'b0;
  wire  out_stall  = rand_stall | hold_stall;

  bit tx_idle_en = 1'b1;
  bit rx_idle_en = 1'b1;

  // Predictor state and its copy of the limit registers.
  phase_t                    parse_phase;
  logic [LENGTH_BITS-1:0]    num_acc;
  bit                        have_digit;
  logic [ARG_INDEX_BITS-1:0] cmd_args;
  logic [ARG_INDEX_BITS-1:0] args_seen;
  logic [LENGTH_BITS-1:0]    bulk_left;
  logic [LENGTH_BITS-1:0]    cur_arg_len;
  logic [MAX_ARGS_BITS-1:0]  lim_args = MAX_ARGS_RST;
  logic [LENGTH_BITS-1:0]    lim_len  = MAX_BULK_LEN_RST;

  out_item_t   predicted_beats[$];
  in_item_t    cmd_q[$];
  int          err_count    = 0;
  int unsigned useful_bytes = 0;
  int unsigned n_payload    = 0;
  int unsigned n_commands   = 0;
  int unsigned n_errors     = 0;
  int          stall_left   = 0;

  resp_command_parser_top dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always #6 clk = ~clk;

  function automatic void clear_parse();
    parse_phase = PH_STAR;
    num_acc     = '0;
    have_digit  = 1'b0;
    cmd_args    = '0;
    args_seen   = '0;
    bulk_left   = '0;
    cur_arg_len = '0;
  endfunction

  // One byte of a decimal header; returns 1 when the byte makes the header malformed.
  function automatic bit digit_step(logic [7:0] b, longint unsigned limit, phase_t nxt);
    longint unsigned v;
    if (b == CH_CR) begin
      if (!have_digit) return 1'b1;
      parse_phase = nxt;
      return 1'b0;
    end
    if (b < CH_ZERO || b > CH_NINE) return 1'b1;
    v = longint'(num_acc) * 10 + longint'(b - CH_ZERO);
    if (v > limit) return 1'b1;
    num_acc    = v[LENGTH_BITS-1:0];
    have_digit = 1'b1;
    return 1'b0;
  endfunction

  function automatic bit parse_byte(input in_item_t it, output out_item_t r);
    logic [7:0] b;
    bit         bad;
    bit         has;
    b   = it.data_byte;
    bad = 1'b0;
    has = 1'b0;
    r   = '0;
    if (it.restart) clear_parse();
    case (parse_phase)
      PH_STAR: begin
        if (b == CH_STAR) begin
          num_acc     = '0;
          have_digit  = 1'b0;
          parse_phase = PH_CNT;
        end else bad = 1'b1;
      end
      PH_CNT: bad = digit_step(b, longint'(lim_args), PH_CNT_LF);
      PH_CNT_LF: begin
        if (b != CH_LF) bad = 1'b1;
        else begin
          cmd_args   = num_acc[ARG_INDEX_BITS-1:0];
          args_seen  = '0;
          num_acc    = '0;
          have_digit = 1'b0;
          if (cmd_args == 0) begin
            parse_phase   = PH_STAR;
            r.command_end = 1'b1;
            has           = 1'b1;
          end else parse_phase = PH_DOLLAR;
        end
      end
      PH_DOLLAR: begin
        if (b == CH_DOLLAR) begin
          num_acc     = '0;
          have_digit  = 1'b0;
          parse_phase = PH_LEN;
        end else bad = 1'b1;
      end
      PH_LEN: bad = digit_step(b, longint'(lim_len), PH_LEN_LF);
      PH_LEN_LF: begin
        if (b != CH_LF) bad = 1'b1;
        else begin
          cur_arg_len = num_acc;
          bulk_left   = num_acc;
          num_acc     = '0;
          have_digit  = 1'b0;
          if (bulk_left == 0) begin
            // An empty argument ends on the LF of its own header.
            parse_phase = PH_SKIP1;
            r.arg_index = args_seen;
            r.arg_end   = 1'b1;
            has         = 1'b1;
          end else parse_phase = PH_DATA;
        end
      end
      PH_DATA: begin
        has             = 1'b1;
        r.payload_valid = 1'b1;
        r.payload_byte  = b;
        r.arg_index     = args_seen;
        bulk_left       = bulk_left - 1'b1;
        if (bulk_left == 0) begin
          r.arg_end    = 1'b1;
          r.arg_length = cur_arg_len;
          parse_phase  = PH_SKIP1;
        end
      end
      PH_SKIP1: parse_phase = PH_SKIP2;
      PH_SKIP2: begin
        args_seen = args_seen + 1'b1;
        if (args_seen >= cmd_args) begin
          parse_phase   = PH_STAR;
          r.command_end = 1'b1;
          r.arg_count   = cmd_args;
          has           = 1'b1;
        end else parse_phase = PH_DOLLAR;
      end
      default: parse_phase = PH_ERR;
    endcase
    if (bad) begin
      parse_phase    = PH_ERR;
      r              = '0;
      r.format_error = 1'b1;
      has            = 1'b1;
    end
    return has;
  endfunction

  function automatic void add_byte(logic [7:0] b, bit rs = 1'b0);
    in_item_t it;
    it.data_byte = b;
    it.restart   = rs;
    cmd_q.insert(cmd_q.size(), it);
  endfunction

  // Marker, decimal value (now and then with a leading zero), CR, LF.
  function automatic void add_header(logic [7:0] marker, longint unsigned value, bit rs = 1'b0);
    string digits;
    digits = $sformatf("%0d", value);
    if ($urandom_range(0, 7) == 0) digits = {"0", digits};
    add_byte(marker, rs);
    for (int i = 0; i < digits.len(); i++) add_byte(digits[i]);
    add_byte(CH_CR);
    add_byte(CH_LF);
  endfunction

  task automatic push_byte(in_item_t it);
    int        gap;
    out_item_t r;
    gap = tx_idle_en ? $urandom_range(0, 13) : 0;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= it;
    do @(posedge clk); while (in_stall);
    if (it.restart || parse_phase != PH_ERR) useful_bytes++;
    if (parse_byte(it, r)) predicted_beats.insert(predicted_beats.size(), r);
  endtask

  task automatic send_queued();
    foreach (cmd_q[i]) push_byte(cmd_q[i]);
    cmd_q.delete();
  endtask

  // Sender pause: every predicted beat must arrive before the block counts as idle.
  task automatic wait_quiet();
    int waited;
    waited = 0;
    in_valid <= 1'b0;
    while (predicted_beats.size() != 0 && waited < 5000) begin
      @(posedge clk);
      waited++;
    end
    if (predicted_beats.size() != 0) begin
      err_count++;
      $display("%0t: %0d expected beats never arrived, next expected 0x%h, actual none",
               $time, predicted_beats.size(), predicted_beats[0]);
      predicted_beats.delete();
    end
    repeat (4) @(posedge clk);
  endtask

  task automatic set_limits(logic [MAX_ARGS_BITS-1:0] a, logic [LENGTH_BITS-1:0] l);
    cfg_valid <= 1'b1;
    cfg_index <= CFG_MAX_ARGS;
    cfg_data  <= {{(LENGTH_BITS-MAX_ARGS_BITS){1'b0}}, a};
    do @(posedge clk); while (!cfg_ready);
    lim_args = a;
    cfg_index <= CFG_MAX_BULK_LEN;
    cfg_data  <= l;
    do @(posedge clk); while (!cfg_ready);
    lim_len = l;
    cfg_valid <= 1'b0;
  endtask

  task automatic send_random_command();
    int unsigned nargs, len, cap;
    int          k, j, pos;
    in_item_t    noise;
    // While the parser sits in error, some bytes go by that it must drop.
    if (parse_phase == PH_ERR && $urandom_range(0, 2) == 0) begin
      repeat ($urandom_range(1, 3)) begin
        noise.data_byte = 8'($urandom_range(0, 255));
        noise.restart   = 1'b0;
        push_byte(noise);
      end
    end
    cap   = (lim_args < 4) ? lim_args : 4;
    nargs = $urandom_range(0, cap);
    if ($urandom_range(0, 11) == 0) add_header(CH_STAR, longint'(lim_args) + 1);
    else add_header(CH_STAR, nargs);
    for (k = 0; k < nargs; k++) begin
      if ($urandom_range(0, 19) == 0) begin
        add_header(CH_DOLLAR, longint'(lim_len) + 1);
        break;
      end
      cap = (lim_len < 8) ? lim_len : 8;
      len = $urandom_range(0, cap);
      if (lim_len > 8 && $urandom_range(0, 15) == 0)
        len = $urandom_range(9, (lim_len < 40) ? lim_len : 40);
      add_header(CH_DOLLAR, len);
      for (j = 0; j < len; j++) add_byte(8'($urandom_range(0, 255)));
      if ($urandom_range(0, 3) == 0) begin
        add_byte(8'($urandom_range(0, 255)));
        add_byte(8'($urandom_range(0, 255)));
      end else begin
        add_byte(CH_CR);
        add_byte(CH_LF);
      end
    end
    cmd_q[0].restart = (parse_phase != PH_STAR) || ($urandom_range(0, 15) == 0);
    // Broken commands: a replaced byte, a restart in the middle, or a cut-off tail.
    if ($urandom_range(0, 9) == 0 && cmd_q.size() > 1) begin
      pos = $urandom_range(1, cmd_q.size() - 1);
      case ($urandom_range(0, 2))
        0: cmd_q[pos].data_byte = 8'($urandom_range(0, 255));
        1: cmd_q[pos].restart = 1'b1;
        default: while (cmd_q.size() > pos) void'(cmd_q.pop_back());
      endcase
    end
    send_queued();
  endtask

  task automatic test_framing();
    tx_idle_en = 1'b1;
    rx_idle_en = 1'b1;
    add_header(CH_STAR, 0);
    add_header(CH_STAR, 2);
    add_header(CH_DOLLAR, 0);
    add_byte(8'hFF);
    add_byte(8'h00);
    add_header(CH_DOLLAR, 2);
    add_byte(8'h00);
    add_byte(8'hFF);
    add_byte(CH_CR);
    add_byte(CH_LF);
    send_queued();
  endtask

  task automatic test_header_errors();
    add_byte("#", 1'b1);
    add_byte(CH_STAR);
    add_byte(CH_STAR, 1'b1);
    add_byte(CH_CR);
    add_byte(CH_STAR, 1'b1);
    add_byte(CH_ZERO + 8'd1);
    add_byte("x");
    add_byte(CH_STAR, 1'b1);
    add_byte(CH_ZERO + 8'd1);
    add_byte(CH_CR);
    add_byte(CH_CR);
    add_header(CH_STAR, 1, 1'b1);
    add_byte(CH_STAR);
    add_header(CH_STAR, 1, 1'b1);
    add_header(CH_DOLLAR, 3);
    add_byte("a");
    add_header(CH_STAR, 0, 1'b1);
    send_queued();
  endtask

  task automatic test_limits();
    wait_quiet();
    set_limits(16'd1, 30'd1);
    add_header(CH_STAR, 1, 1'b1);
    add_header(CH_DOLLAR, 1);
    add_byte(8'hA5);
    add_byte(CH_CR);
    add_byte(CH_LF);
    add_header(CH_STAR, 2, 1'b1);
    add_header(CH_STAR, 1, 1'b1);
    add_header(CH_DOLLAR, 2);
    send_queued();
    wait_quiet();
    set_limits(16'hFFFF, MAX_BULK_LEN_RST);
    add_header(CH_STAR, 65535, 1'b1);
    add_header(CH_DOLLAR, MAX_BULK_LEN_RST);
    add_byte(8'h5A);
    add_header(CH_STAR, 65536, 1'b1);
    add_header(CH_STAR, 1, 1'b1);
    add_header(CH_DOLLAR, longint'(MAX_BULK_LEN_RST) + 1);
    send_queued();
    wait_quiet();
    // Two-digit values over a one-digit limit fail on the second digit.
    set_limits(16'd9, 30'd9);
    add_header(CH_STAR, 10, 1'b1);
    add_header(CH_STAR, 1, 1'b1);
    add_header(CH_DOLLAR, 10);
    send_queued();
    wait_quiet();
    set_limits(MAX_ARGS_RST, MAX_BULK_LEN_RST);
  endtask

  task automatic test_backpressure();
    int k, j;
    tx_idle_en = 1'b0;
    rx_idle_en = 1'b0;
    wait_quiet();
    fork
      begin
        hold_stall <= 1'b1;
        repeat (80) @(posedge clk);
        hold_stall <= 1'b0;
      end
    join_none
    add_header(CH_STAR, 2, 1'b1);
    for (k = 0; k < 2; k++) begin
      add_header(CH_DOLLAR, 24);
      for (j = 0; j < 24; j++) add_byte(8'($urandom_range(0, 255)));
      add_byte(CH_CR);
      add_byte(CH_LF);
    end
    send_queued();
    wait_quiet();
  endtask

  task automatic run_traffic(logic [MAX_ARGS_BITS-1:0] a, logic [LENGTH_BITS-1:0] l,
                             bit tx_idle, bit rx_idle, int unsigned n_bytes);
    int unsigned stop_at;
    wait_quiet();
    set_limits(a, l);
    tx_idle_en = tx_idle;
    rx_idle_en = rx_idle;
    stop_at    = useful_bytes + n_bytes;
    while (useful_bytes < stop_at) send_random_command();
  endtask

  task automatic test_random_traffic();
    run_traffic(MAX_ARGS_RST, MAX_BULK_LEN_RST, 1'b1, 1'b1, 110);
    run_traffic(16'd1, 30'd1, 1'b0, 1'b0, 110);
    run_traffic(16'hFFFF, MAX_BULK_LEN_RST, 1'b1, 1'b0, 110);
    run_traffic(16'($urandom_range(1, 6)), 30'($urandom_range(1, 12)), 1'b0, 1'b1, 110);
    run_traffic(16'($urandom_range(1, 65535)), 30'($urandom_range(1, MAX_BULK_LEN_RST)),
                1'b1, 1'b1, 110);
    run_traffic(16'd3, 30'd5, 1'b1, 1'b1, 110);
  endtask

  // Receiver: while rx_idle_en is set, stall at random after accepted beats and now and then while idle.
  always @(posedge clk) begin
    if (rx_idle_en && stall_left == 0) begin
      if (out_valid && !out_stall) stall_left = $urandom_range(0, 13);
      else if ($urandom_range(0, 15) == 0) stall_left = $urandom_range(1, 13);
    end
    if (stall_left > 0) begin
      stall_left--;
      rand_stall <= 1'b1;
    end else begin
      rand_stall <= 1'b0;
    end
  end

  function automatic void check_field(string name, longint unsigned want, longint unsigned got);
    if (want !== got) begin
      err_count++;
      $display("%0t: %s mismatch, expected 0x%0h, actual 0x%0h", $time, name, want, got);
    end
  endfunction

  always @(posedge clk) begin : check_results
    out_item_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (predicted_beats.size() == 0) begin
        err_count++;
        $display("%0t: result beat with nothing expected, expected none, actual 0x%h",
                 $time, out_data);
      end else begin
        want = predicted_beats.pop_front();
        check_field("payload_valid", want.payload_valid, out_data.payload_valid);
        check_field("payload_byte", want.payload_byte, out_data.payload_byte);
        check_field("arg_index", want.arg_index, out_data.arg_index);
        check_field("arg_end", want.arg_end, out_data.arg_end);
        check_field("arg_length", want.arg_length, out_data.arg_length);
        check_field("command_end", want.command_end, out_data.command_end);
        check_field("arg_count", want.arg_count, out_data.arg_count);
        check_field("format_error", want.format_error, out_data.format_error);
        if (want.payload_valid) n_payload++;
        if (want.command_end) n_commands++;
        if (want.format_error) n_errors++;
      end
    end
  end

  initial begin
    #5_000_000;
    $display("Run timed out with %0d beats still expected.", predicted_beats.size());
    $display("resp_command_parser_top regression: fail");
    $finish;
  end

  initial begin
    clear_parse();
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    test_framing();
    test_header_errors();
    test_limits();
    test_backpressure();
    test_random_traffic();
    wait_quiet();
    $display("Parsed %0d live input bytes over six limit settings with idle and stall gaps.",
             useful_bytes);
    $display("Checked %0d payload beats, %0d command ends and %0d format errors.",
             n_payload, n_commands, n_errors);
    if (err_count == 0) begin
      $display("resp_command_parser_top regression: pass");
    end else begin
      $display("resp_command_parser_top regression: fail");
    end
    $finish;
  end

endmodule
